// ===== design/hic_pkg.sv =====
// package: constants, types and transform functions for the hilbert index codec
`timescale 1ns / 1ps

package hic_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MAX_BITS   = 16;
  localparam int COORD_W    = 16;
  localparam int DIST_W     = 64;
  localparam int DIMS_W     = 3;
  localparam int BITS_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int GRAY_STG = MAX_BITS;
  localparam int OUT_STG  = MAX_BITS + 1;
  localparam int NSTG     = MAX_BITS + 2;

  typedef logic [COORD_W-1:0]          crd_t;
  typedef crd_t [MAX_DIMS-1:0]         crd_vec_t;
  typedef logic [DIST_W-1:0]           dist_t;
  typedef logic [DIMS_W-1:0]           dims_t;
  typedef logic [BITS_W-1:0]           bits_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]       cfg_data_t;

  localparam cfg_idx_t REG_DIMS = cfg_idx_t'(0);
  localparam cfg_idx_t REG_BITS = cfg_idx_t'(1);

  localparam dims_t DIMS_RST = dims_t'(2);
  localparam bits_t BITS_RST = bits_t'(16);

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // one fold level over the active dimensions, ascending or descending
  function automatic crd_vec_t fold_step(crd_vec_t x, dims_t nd, crd_t q, logic down);
    crd_vec_t y;
    crd_t     p;
    crd_t     t;
    int       s;
    int       i;
    y = x;
    p = q - crd_t'(1);
    for (s = 0; s < MAX_DIMS; s++) begin
      i = down ? (MAX_DIMS - 1 - s) : s;
      if (i < int'(nd)) begin
        if ((y[i] & q) != '0) begin
          y[0] = y[0] ^ p;
        end else begin
          t    = (y[0] ^ y[i]) & p;
          y[0] = y[0] ^ t;
          y[i] = y[i] ^ t;
        end
      end
    end
    return y;
  endfunction

  function automatic crd_t last_axis(crd_vec_t x, dims_t nd);
    crd_t r;
    int   i;
    r = x[0];
    for (i = 1; i < MAX_DIMS; i++) begin
      if (i == int'(nd) - 1) begin
        r = x[i];
      end
    end
    return r;
  endfunction

  function automatic dist_t interleave(crd_vec_t x, dims_t nd, bits_t nb);
    dist_t h;
    int    d;
    int    b;
    int    i;
    h = '0;
    for (d = 1; d <= MAX_DIMS; d++) begin
      if (int'(nd) == d) begin
        for (b = 0; b < MAX_BITS; b++) begin
          for (i = 0; i < MAX_DIMS; i++) begin
            if (i < d && b < int'(nb) && (b * d + i) < DIST_W) begin
              h[b * d + i] = x[i][b];
            end
          end
        end
      end
    end
    return h;
  endfunction

  function automatic crd_vec_t deinterleave(dist_t h, dims_t nd, bits_t nb);
    crd_vec_t x;
    int       d;
    int       b;
    int       i;
    x = '0;
    for (d = 1; d <= MAX_DIMS; d++) begin
      if (int'(nd) == d) begin
        for (b = 0; b < MAX_BITS; b++) begin
          for (i = 0; i < MAX_DIMS; i++) begin
            if (i < d && b < int'(nb) && (b * d + i) < DIST_W) begin
              x[i][b] = h[b * d + i];
            end
          end
        end
      end
    end
    return x;
  endfunction

  function automatic crd_vec_t gray_decode(crd_vec_t x, dims_t nd);
    crd_vec_t y;
    crd_t     t;
    int       i;
    y = x;
    t = last_axis(x, nd) >> 1;
    for (i = MAX_DIMS - 1; i > 0; i--) begin
      if (i < int'(nd)) begin
        y[i] = x[i] ^ x[i-1];
      end
    end
    y[0] = x[0] ^ t;
    return y;
  endfunction

  function automatic crd_vec_t gray_encode(crd_vec_t x, dims_t nd);
    crd_vec_t g;
    crd_t     last;
    crd_t     t;
    int       i;
    int       k;
    g = x;
    for (i = 1; i < MAX_DIMS; i++) begin
      if (i < int'(nd)) begin
        g[i] = g[i-1] ^ x[i];
      end
    end
    last = last_axis(g, nd);
    for (k = 0; k < COORD_W; k++) begin
      t[k] = ^(last >> (k + 1));
    end
    for (i = 0; i < MAX_DIMS; i++) begin
      if (i < int'(nd)) begin
        g[i] = g[i] ^ t;
      end
    end
    return g;
  endfunction

endpackage

// ===== design/hic_ifs.sv =====
// interfaces: input item, result item and configuration write channels
`timescale 1ns / 1ps

interface hic_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  hic_pkg::crd_t coord_0;
  hic_pkg::crd_t coord_1;
  hic_pkg::crd_t coord_2;
  hic_pkg::crd_t coord_3;
  hic_pkg::dist_t distance;

  modport source (output valid, action, coord_0, coord_1, coord_2, coord_3, distance,
                  input ready);
  modport sink   (input valid, action, coord_0, coord_1, coord_2, coord_3, distance,
                  output ready);
endinterface

interface hic_out_if;
  logic           valid;
  logic           ready;
  hic_pkg::dist_t result_distance;
  hic_pkg::crd_t  out_coord_0;
  hic_pkg::crd_t  out_coord_1;
  hic_pkg::crd_t  out_coord_2;
  hic_pkg::crd_t  out_coord_3;

  modport source (output valid, result_distance, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, input ready);
  modport sink   (input valid, result_distance, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, output ready);
endinterface

interface hic_cfg_if;
  logic               valid;
  logic               ready;
  hic_pkg::cfg_idx_t  idx;
  hic_pkg::cfg_data_t data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== design/hilbert_index_codec_core.sv =====
// top level: pipelined hilbert curve encoder and decoder (transposed transform)
// one item per cycle sustained while the output side is not back-pressured
// one fold level of the transform per pipeline stage, plus entry, gray and output stages
// each stage holds its item under stall; a stage with room accepts regardless of later ones
// synchronous active-low reset clears all valid bits and loads dims 2 and bits 16
// no clearing pass after reset
`timescale 1ns / 1ps

module hilbert_index_codec_core (
  input  logic      clk,
  input  logic      rst_n,
  hic_in_if.sink    in_ch,
  hic_out_if.source out_ch,
  hic_cfg_if.sink   cfg_ch
);

  hic_pkg::dims_t    dims_r;
  hic_pkg::bits_t    bits_r;
  hic_pkg::dims_t    nd;
  hic_pkg::bits_t    nb;
  hic_pkg::crd_t     cmask;

  logic [hic_pkg::NSTG-1:0] vld_r;
  logic [hic_pkg::NSTG-1:0] rdy;

  hic_pkg::crd_vec_t x_r   [0:hic_pkg::GRAY_STG];
  hic_pkg::crd_vec_t x_nxt [0:hic_pkg::GRAY_STG];
  logic              act_r   [0:hic_pkg::GRAY_STG];
  logic              act_nxt [0:hic_pkg::GRAY_STG];

  hic_pkg::dist_t    dist_out_r;
  hic_pkg::dist_t    dist_out_nxt;
  hic_pkg::crd_vec_t crd_out_r;
  hic_pkg::crd_vec_t crd_out_nxt;

  hic_pkg::crd_vec_t enc_in;
  hic_pkg::crd_vec_t dec_out;
  hic_pkg::crd_t     q;
  int                qbit;

  // effective configuration
  always_comb begin
    if (dims_r == '0) begin
      nd = hic_pkg::dims_t'(1);
    end else if (int'(dims_r) > hic_pkg::MAX_DIMS) begin
      nd = hic_pkg::dims_t'(hic_pkg::MAX_DIMS);
    end else begin
      nd = dims_r;
    end
    if (bits_r == '0) begin
      nb = hic_pkg::bits_t'(1);
    end else if (int'(bits_r) > hic_pkg::MAX_BITS) begin
      nb = hic_pkg::bits_t'(hic_pkg::MAX_BITS);
    end else begin
      nb = bits_r;
    end
    for (int k = 0; k < hic_pkg::COORD_W; k++) begin
      cmask[k] = (k < int'(nb));
    end
  end

  // per-stage ready chain
  always_comb begin
    rdy[hic_pkg::NSTG-1] = !vld_r[hic_pkg::NSTG-1] || out_ch.ready;
    for (int k = hic_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready  = rdy[0];
  assign cfg_ch.ready = 1'b1;

  // stage datapath
  always_comb begin
    enc_in[0] = in_ch.coord_0 & cmask;
    enc_in[1] = in_ch.coord_1 & cmask;
    enc_in[2] = in_ch.coord_2 & cmask;
    enc_in[3] = in_ch.coord_3 & cmask;
    for (int i = 0; i < hic_pkg::MAX_DIMS; i++) begin
      if (i >= int'(nd)) begin
        enc_in[i] = '0;
      end
    end
    act_nxt[0] = in_ch.action;
    if (in_ch.action == hic_pkg::ACT_DECODE) begin
      x_nxt[0] = hic_pkg::gray_decode(hic_pkg::deinterleave(in_ch.distance, nd, nb), nd);
    end else begin
      x_nxt[0] = enc_in;
    end

    q    = '0;
    qbit = 0;
    for (int k = 1; k < hic_pkg::GRAY_STG; k++) begin
      act_nxt[k] = act_r[k-1];
      x_nxt[k]   = x_r[k-1];
      if (k < int'(nb)) begin
        if (act_r[k-1] == hic_pkg::ACT_DECODE) begin
          qbit = k;
        end else begin
          qbit = int'(nb) - k;
        end
        q        = hic_pkg::crd_t'(1) << qbit;
        x_nxt[k] = hic_pkg::fold_step(x_r[k-1], nd, q, act_r[k-1]);
      end
    end

    act_nxt[hic_pkg::GRAY_STG] = act_r[hic_pkg::GRAY_STG-1];
    if (act_r[hic_pkg::GRAY_STG-1] == hic_pkg::ACT_DECODE) begin
      x_nxt[hic_pkg::GRAY_STG] = x_r[hic_pkg::GRAY_STG-1];
    end else begin
      x_nxt[hic_pkg::GRAY_STG] = hic_pkg::gray_encode(x_r[hic_pkg::GRAY_STG-1], nd);
    end

    for (int i = 0; i < hic_pkg::MAX_DIMS; i++) begin
      dec_out[i] = (i < int'(nd)) ? (x_r[hic_pkg::GRAY_STG][i] & cmask) : '0;
    end
    if (act_r[hic_pkg::GRAY_STG] == hic_pkg::ACT_DECODE) begin
      dist_out_nxt = '0;
      crd_out_nxt  = dec_out;
    end else begin
      dist_out_nxt = hic_pkg::interleave(x_r[hic_pkg::GRAY_STG], nd, nb);
      crd_out_nxt  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      dims_r <= hic_pkg::DIMS_RST;
      bits_r <= hic_pkg::BITS_RST;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < hic_pkg::NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          hic_pkg::REG_DIMS: dims_r <= cfg_ch.data[hic_pkg::DIMS_W-1:0];
          hic_pkg::REG_BITS: bits_r <= cfg_ch.data[hic_pkg::BITS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int k = 0; k <= hic_pkg::GRAY_STG; k++) begin
      if (rdy[k]) begin
        x_r[k]   <= x_nxt[k];
        act_r[k] <= act_nxt[k];
      end
    end
    if (rdy[hic_pkg::OUT_STG]) begin
      dist_out_r <= dist_out_nxt;
      crd_out_r  <= crd_out_nxt;
    end
  end

  assign out_ch.valid           = vld_r[hic_pkg::OUT_STG];
  assign out_ch.result_distance = dist_out_r;
  assign out_ch.out_coord_0     = crd_out_r[0];
  assign out_ch.out_coord_1     = crd_out_r[1];
  assign out_ch.out_coord_2     = crd_out_r[2];
  assign out_ch.out_coord_3     = crd_out_r[3];

endmodule

// ===== dv/tb.sv =====
// testbench: random and directed hilbert encode and decode items checked against a bench model
`timescale 1ns / 1ps

module tb;
  import hic_pkg::*;

  localparam int       LIMIT     = 200000;
  localparam cfg_idx_t REG_SPARE = cfg_idx_t'(3);

  typedef bit [63:0] word_t;
  typedef bit [MAX_DIMS-1:0][63:0] axes_t;

  typedef struct packed {
    logic     action;
    crd_vec_t crd;
    dist_t    hdist;
  } codec_req_t;

  typedef struct packed {
    dist_t    hdist;
    crd_vec_t crd;
  } codec_res_t;

  class conversion_book;
    dims_t      dims_reg;
    bits_t      bits_reg;
    codec_res_t due_results[$];
    int         errors;

    function new();
      dims_reg = DIMS_RST;
      bits_reg = BITS_RST;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      if (idx == REG_DIMS) begin
        dims_reg = data[DIMS_W-1:0];
      end else if (idx == REG_BITS) begin
        bits_reg = data[BITS_W-1:0];
      end
    endfunction

    function int active_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > MAX_DIMS) return MAX_DIMS;
      return int'(dims_reg);
    endfunction

    function int active_bits();
      if (bits_reg == 0) return 1;
      if (bits_reg > MAX_BITS) return MAX_BITS;
      return int'(bits_reg);
    endfunction

    function axes_t fold_axes(axes_t x, int nd, word_t q, bit down);
      word_t p;
      word_t t;
      int    i;
      p = q - 64'd1;
      for (int s = 0; s < nd; s++) begin
        i = down ? (nd - 1 - s) : s;
        if ((x[i] & q) != 0) begin
          x[0] ^= p;
        end else begin
          t = (x[0] ^ x[i]) & p;
          x[0] ^= t;
          x[i] ^= t;
        end
      end
      return x;
    endfunction

    function word_t coords_to_distance(axes_t x, int nd, int nb);
      word_t m;
      word_t q;
      word_t t;
      word_t h;
      int    pos;
      m = 64'd1 << (nb - 1);
      t = '0;
      h = '0;
      for (q = m; q > 1; q >>= 1) x = fold_axes(x, nd, q, 1'b0);
      for (int i = 1; i < nd; i++) x[i] ^= x[i-1];
      for (q = m; q > 1; q >>= 1) begin
        if ((x[nd-1] & q) != 0) t ^= q - 64'd1;
      end
      for (int i = 0; i < nd; i++) x[i] ^= t;
      for (int b = 0; b < nb; b++) begin
        for (int i = 0; i < nd; i++) begin
          pos = b * nd + i;
          if (pos < 64) h[pos] = x[i][b];
        end
      end
      return h;
    endfunction

    function axes_t distance_to_coords(word_t h, int nd, int nb);
      axes_t x;
      word_t lim;
      word_t q;
      word_t t;
      int    pos;
      x = '0;
      for (int b = 0; b < nb; b++) begin
        for (int i = 0; i < nd; i++) begin
          pos = b * nd + i;
          if (pos < 64) x[i][b] = h[pos];
        end
      end
      t = x[nd-1] >> 1;
      for (int i = nd - 1; i > 0; i--) x[i] ^= x[i-1];
      x[0] ^= t;
      lim = 64'd1 << nb;
      for (q = 64'd2; q < lim; q <<= 1) x = fold_axes(x, nd, q, 1'b1);
      return x;
    endfunction

    function void note_item(codec_req_t r);
      codec_res_t e;
      axes_t      x;
      word_t      cmask;
      int         nd;
      int         nb;
      nd    = active_dims();
      nb    = active_bits();
      cmask = (64'd1 << nb) - 64'd1;
      e     = '0;
      if (r.action == ACT_ENCODE) begin
        x = '0;
        for (int i = 0; i < nd; i++) x[i] = word_t'(r.crd[i]) & cmask;
        e.hdist = coords_to_distance(x, nd, nb);
      end else begin
        x = distance_to_coords(r.hdist, nd, nb);
        for (int i = 0; i < nd; i++) e.crd[i] = x[i][COORD_W-1:0] & cmask[COORD_W-1:0];
      end
      due_results.push_back(e);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(codec_res_t got);
      codec_res_t e;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result: distance %h coords %h", got.hdist, got.crd));
        return;
      end
      e = due_results.pop_front();
      if (got.hdist !== e.hdist) begin
        flag($sformatf("result_distance mismatch: expected %h got %h", e.hdist, got.hdist));
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
        if (got.crd[i] !== e.crd[i]) begin
          flag($sformatf("out_coord_%0d mismatch: expected %h got %h", i, e.crd[i],
                         got.crd[i]));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;

  hic_in_if  in_ch ();
  hic_out_if out_ch ();
  hic_cfg_if cfg_ch ();

  conversion_book book = new();

  hilbert_index_codec_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic codec_req_t make_req(logic act, crd_t c0, crd_t c1, crd_t c2, crd_t c3,
                                          dist_t d);
    codec_req_t r;
    r.action = act;
    r.crd[0] = c0;
    r.crd[1] = c1;
    r.crd[2] = c2;
    r.crd[3] = c3;
    r.hdist  = d;
    return r;
  endfunction

  function automatic codec_req_t random_req();
    codec_req_t r;
    int         sh;
    r.action = ($urandom_range(0, 1) == 1) ? ACT_DECODE : ACT_ENCODE;
    for (int i = 0; i < MAX_DIMS; i++) r.crd[i] = crd_t'($urandom_range(0, 65535));
    r.hdist = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      sh      = $urandom_range(0, 15);
      r.hdist = r.hdist >> $urandom_range(0, 63);
      for (int i = 0; i < MAX_DIMS; i++) r.crd[i] = r.crd[i] >> sh;
    end
    return r;
  endfunction

  task automatic send(codec_req_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= r.action;
    in_ch.coord_0  <= r.crd[0];
    in_ch.coord_1  <= r.crd[1];
    in_ch.coord_2  <= r.crd[2];
    in_ch.coord_3  <= r.crd[3];
    in_ch.distance <= r.hdist;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(cfg_data_t dims_data, cfg_data_t bits_data, bit spare);
    drain();
    write_reg(REG_DIMS, dims_data);
    write_reg(REG_BITS, bits_data);
    if (spare) write_reg(REG_SPARE, cfg_data_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // output side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) book.write_reg(cfg_ch.idx, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        book.note_item(make_req(in_ch.action, in_ch.coord_0, in_ch.coord_1, in_ch.coord_2,
                                in_ch.coord_3, in_ch.distance));
      end
      if (out_ch.valid && out_ch.ready) begin
        book.check_result(codec_res_t'({out_ch.result_distance, out_ch.out_coord_3,
                                        out_ch.out_coord_2, out_ch.out_coord_1,
                                        out_ch.out_coord_0}));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[hilbert_index_codec_core] ERROR");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    calm           = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_ENCODE;
    in_ch.coord_0  <= '0;
    in_ch.coord_1  <= '0;
    in_ch.coord_2  <= '0;
    in_ch.coord_3  <= '0;
    in_ch.distance <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.idx     <= REG_DIMS;
    cfg_ch.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: two dims, sixteen bits
    send(make_req(ACT_ENCODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0));
    send(make_req(ACT_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
    send(make_req(ACT_ENCODE, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF, '0));
    send(make_req(ACT_DECODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  64'hFFFF_FFFF_0000_0001));

    configure(8'h04, 8'h10, 1'b0);
    send(make_req(ACT_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  64'h8000_0000_0000_0000));

    configure(8'h01, 8'h01, 1'b1);
    send(make_req(ACT_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 64'h1));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1));

    // zero dims and zero bits act as one
    configure(8'hF8, 8'hE0, 1'b0);
    send(make_req(ACT_ENCODE, 16'h0001, 16'h0000, 16'h0000, 16'h0000, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  64'hFFFF_FFFF_FFFF_FFFE));

    // over-range dims and bits clamp to the maximum
    configure(8'h07, 8'hFF, 1'b0);
    send(make_req(ACT_ENCODE, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  64'hA5A5_5A5A_C3C3_3C3C));

    configure(8'h03, 8'h05, 1'b0);
    send(make_req(ACT_ENCODE, 16'hFFFF, 16'h001F, 16'h0010, 16'h0001, '0));
    send(make_req(ACT_DECODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1));

    for (int k = 0; k < 11; k++) begin
      if (k == 10) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        configure(cfg_data_t'($urandom_range(0, 255)), cfg_data_t'($urandom_range(0, 255)),
                  1'b0);
      end else begin
        configure(cfg_data_t'($urandom_range(1, 4)), cfg_data_t'($urandom_range(1, 16)),
                  1'b0);
      end
      repeat (55) send(random_req());
    end

    drain();
    repeat (40) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("[hilbert_index_codec_core] OK");
    end else begin
      $display("[hilbert_index_codec_core] ERROR");
    end
    $finish;
  end

endmodule
